### src/qexp_pkg.sv
// Shared types, constants and helper functions for the quaternion exponential block.
package qexp_pkg;

	// Fixed-point constants in Q.30.
	localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
	localparam logic [33:0] PI_Q30      = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

	// Reset value of the small angle threshold, Q4.28.
	localparam logic [30:0] THRESH_RESET = 31'd268;

	// Taylor series length and the queue between the front and back parts.
	localparam int SERIES_TERMS = 7;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	// Back pipeline: square root, reduction, series, clamp, divide, multiply and pack.
	localparam int BACK_STAGES = 32 + 5 + 3 * SERIES_TERMS + 1 + 32 + 2;

	// Vector part of one input word.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	// Queue word: the vector and its sum of squares.
	typedef struct packed {
		vec_t        v;
		logic [63:0] sum;
	} work_t;

	// Result word.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
	} res_t;

	// Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] m;
		m = v[31] ? 32'(-v) : 32'(v);
		return m;
	endfunction

	// Divisor of sine term k: (2k)(2k+1).
	function automatic logic [7:0] sin_div(input logic [2:0] k);
		logic [7:0] d;
		case (k)
			3'd1: d = 8'd6;
			3'd2: d = 8'd20;
			3'd3: d = 8'd42;
			3'd4: d = 8'd72;
			3'd5: d = 8'd110;
			3'd6: d = 8'd156;
			3'd7: d = 8'd210;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	// Divisor of cosine term k: (2k-1)(2k).
	function automatic logic [7:0] cos_div(input logic [2:0] k);
		logic [7:0] d;
		case (k)
			3'd1: d = 8'd2;
			3'd2: d = 8'd12;
			3'd3: d = 8'd30;
			3'd4: d = 8'd56;
			3'd5: d = 8'd90;
			3'd6: d = 8'd132;
			3'd7: d = 8'd182;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	// Reciprocal floor(2^34 / d) of each sine divisor.
	function automatic logic [33:0] sin_rcp(input logic [2:0] k);
		logic [33:0] r;
		case (k)
			3'd1: r = 34'd2863311530;
			3'd2: r = 34'd858993459;
			3'd3: r = 34'd409044504;
			3'd4: r = 34'd238609294;
			3'd5: r = 34'd156180628;
			3'd6: r = 34'd110127366;
			3'd7: r = 34'd81808900;
			default: r = 34'd0;
		endcase
		return r;
	endfunction

	// Reciprocal floor(2^34 / d) of each cosine divisor.
	function automatic logic [33:0] cos_rcp(input logic [2:0] k);
		logic [33:0] r;
		case (k)
			3'd1: r = 34'd8589934592;
			3'd2: r = 34'd1431655765;
			3'd3: r = 34'd572662306;
			3'd4: r = 34'd306783378;
			3'd5: r = 34'd190887435;
			3'd6: r = 34'd130150524;
			3'd7: r = 34'd94394885;
			default: r = 34'd0;
		endcase
		return r;
	endfunction

endpackage

### src/qexp_front.sv
// Front part: accepts input words and forms the sum of squares of the vector.
module qexp_front import qexp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  vec_t        vec_in,
	input  logic        q_full,
	output logic        push,
	output work_t       push_word
);

	logic        v_s1, v_s2, v_s3;
	vec_t        vec_s1, vec_s2, vec_s3;
	logic [63:0] sq_s2 [0:2];
	logic [63:0] sum_s3;
	logic        adv;

	// The front advances unless its last word cannot enter the queue.
	assign adv      = !v_s3 || !q_full;
	assign in_stall = !adv;
	assign push     = v_s3 && !q_full;

	assign push_word.v   = vec_s3;
	assign push_word.sum = sum_s3;

	// Valid bits of the three front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Capture, square each component, then add the squares.
	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s1   <= vec_in;
			vec_s2   <= vec_s1;
			sq_s2[0] <= {32'd0, mag32(vec_s1.x)} * {32'd0, mag32(vec_s1.x)};
			sq_s2[1] <= {32'd0, mag32(vec_s1.y)} * {32'd0, mag32(vec_s1.y)};
			sq_s2[2] <= {32'd0, mag32(vec_s1.z)} * {32'd0, mag32(vec_s1.z)};
			vec_s3   <= vec_s2;
			sum_s3   <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

endmodule

### src/qexp_queue.sv
// Short queue of words between the front and back parts.
module qexp_queue import qexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_word,
	output logic  full,
	input  logic  pop,
	output work_t head,
	output logic  nonempty
);

	work_t               mem_q [0:QUEUE_DEPTH-1];
	logic [QUEUE_AW-1:0] wp_q, rp_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full     = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_word;
	end

endmodule

### src/qexp_back.sv
// Back part: square root, sine and cosine, scale division and the final products.
module qexp_back import qexp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  work_t       q_word,
	output logic        pop,
	input  logic [30:0] thr,
	output logic        out_valid,
	input  logic        out_stall,
	output res_t        res
);

	typedef struct packed {
		logic [65:0] rem;
		logic [31:0] root;
		vec_t        v;
	} sq_t;

	typedef struct packed {
		logic [33:0] a;
		logic [31:0] theta;
		logic        sneg;
		logic        cneg;
		vec_t        v;
	} rd_t;

	typedef struct packed {
		logic [30:0]        ts;
		logic [30:0]        tc;
		logic signed [33:0] ss;
		logic signed [33:0] cs;
		logic [31:0]        x2;
		logic [31:0]        theta;
		logic               sneg;
		logic               cneg;
		vec_t               v;
	} ser_t;

	typedef struct packed {
		logic [30:0] smag;
		logic        sgn;
		logic        above;
		logic [31:0] theta;
		logic [31:0] w;
		vec_t        v;
	} cl_t;

	typedef struct packed {
		logic [62:0] rem;
		logic [30:0] quo;
		logic [31:0] theta;
		logic        ovf;
		logic        above;
		logic        sgn;
		logic [31:0] w;
		vec_t        v;
	} dv_t;

	logic [BACK_STAGES-1:0] v_q;
	logic                   ben;

	sq_t  sq_in [0:31];
	sq_t  sq_nx [0:31];
	sq_t  sq_q  [1:32];

	logic [33:0] a0;
	rd_t  rd1_q, rd2_q, rd3_q, rd4_q;
	logic [61:0] r2;
	ser_t rd5_q;

	ser_t        se_in  [0:SERIES_TERMS-1];
	ser_t        sm_q   [0:SERIES_TERMS-1];
	logic [62:0] sm_ps  [0:SERIES_TERMS-1];
	logic [62:0] sm_pc  [0:SERIES_TERMS-1];
	ser_t        sqq_q  [0:SERIES_TERMS-1];
	logic [32:0] qs_q   [0:SERIES_TERMS-1];
	logic [32:0] qc_q   [0:SERIES_TERMS-1];
	logic [32:0] es_q   [0:SERIES_TERMS-1];
	logic [32:0] ec_q   [0:SERIES_TERMS-1];
	ser_t        se_nx  [0:SERIES_TERMS-1];
	ser_t        se_q   [1:SERIES_TERMS];

	logic [30:0] s_cl, c_cl;
	cl_t  cl_q;

	dv_t  dv_nx [0:30];
	dv_t  dv_q  [0:31];

	logic [30:0] scl;
	logic [62:0] mu_m_q [0:2];
	logic        mu_n_q [0:2];
	logic [31:0] mu_w_q;
	logic [31:0] pk [0:2];
	res_t res_q;

	// The whole back pipeline moves together unless the output word is held.
	assign ben       = !v_q[BACK_STAGES-1] || !out_stall;
	assign pop       = ben && q_valid;
	assign out_valid = v_q[BACK_STAGES-1];
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (ben) v_q <= {v_q[BACK_STAGES-2:0], q_valid};
	end

	// Square root, one result bit per stage from the remainder.
	always_comb begin
		sq_in[0].rem  = {2'b00, q_word.sum};
		sq_in[0].root = '0;
		sq_in[0].v    = q_word.v;
		for (int i = 1; i < 32; i++) sq_in[i] = sq_q[i];
	end

	always_comb begin
		logic [65:0] trial;
		for (int i = 0; i < 32; i++) begin
			trial    = ({34'd0, sq_in[i].root} << (32 - i)) + (66'd1 << (2 * (31 - i)));
			sq_nx[i] = sq_in[i];
			if (sq_in[i].rem >= trial) begin
				sq_nx[i].rem         = sq_in[i].rem - trial;
				sq_nx[i].root[31 - i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ben) for (int i = 0; i < 32; i++) sq_q[i + 1] <= sq_nx[i];
	end

	// Angle reduction modulo two pi, then folding into the first quadrant.
	assign a0 = {sq_q[32].root, 2'b00};
	assign r2 = {31'd0, rd4_q.a[30:0]} * {31'd0, rd4_q.a[30:0]};

	always_ff @(posedge clk) begin
		if (ben) begin
			rd1_q.a     <= (a0 >= TWO_PI_Q30) ? a0 - TWO_PI_Q30 : a0;
			rd1_q.theta <= sq_q[32].root;
			rd1_q.sneg  <= 1'b0;
			rd1_q.cneg  <= 1'b0;
			rd1_q.v     <= sq_q[32].v;

			rd2_q.a     <= (rd1_q.a >= TWO_PI_Q30) ? rd1_q.a - TWO_PI_Q30 : rd1_q.a;
			rd2_q.theta <= rd1_q.theta;
			rd2_q.sneg  <= rd1_q.sneg;
			rd2_q.cneg  <= rd1_q.cneg;
			rd2_q.v     <= rd1_q.v;

			rd3_q.a     <= (rd2_q.a > PI_Q30) ? TWO_PI_Q30 - rd2_q.a : rd2_q.a;
			rd3_q.theta <= rd2_q.theta;
			rd3_q.sneg  <= rd2_q.sneg || (rd2_q.a > PI_Q30);
			rd3_q.cneg  <= rd2_q.cneg;
			rd3_q.v     <= rd2_q.v;

			rd4_q.a     <= (rd3_q.a > HALF_PI_Q30) ? PI_Q30 - rd3_q.a : rd3_q.a;
			rd4_q.theta <= rd3_q.theta;
			rd4_q.sneg  <= rd3_q.sneg;
			rd4_q.cneg  <= rd3_q.cneg || (rd3_q.a > HALF_PI_Q30);
			rd4_q.v     <= rd3_q.v;

			// Series start: square of the angle and the leading terms.
			rd5_q.ts    <= rd4_q.a[30:0];
			rd5_q.tc    <= ONE_Q30;
			rd5_q.ss    <= $signed({3'b000, rd4_q.a[30:0]});
			rd5_q.cs    <= $signed({3'b000, ONE_Q30});
			rd5_q.x2    <= r2[61:30];
			rd5_q.theta <= rd4_q.theta;
			rd5_q.sneg  <= rd4_q.sneg;
			rd5_q.cneg  <= rd4_q.cneg;
			rd5_q.v     <= rd4_q.v;
		end
	end

	// Series terms: multiply by the angle squared, multiply by the divisor's reciprocal, correct and add.
	always_comb begin
		se_in[0] = rd5_q;
		for (int k = 1; k < SERIES_TERMS; k++) se_in[k] = se_q[k];
	end

	always_comb begin
		logic [32:0] rs, rc, ns, nc;
		logic [7:0]  ds, dc;
		for (int k = 0; k < SERIES_TERMS; k++) begin
			ds       = sin_div(3'(k + 1));
			dc       = cos_div(3'(k + 1));
			rs       = qs_q[k] - 33'(es_q[k] * {25'd0, ds});
			rc       = qc_q[k] - 33'(ec_q[k] * {25'd0, dc});
			ns       = es_q[k] + ((rs >= {25'd0, ds}) ? 33'd1 : 33'd0);
			nc       = ec_q[k] + ((rc >= {25'd0, dc}) ? 33'd1 : 33'd0);
			se_nx[k]    = sqq_q[k];
			se_nx[k].ts = ns[30:0];
			se_nx[k].tc = nc[30:0];
			if ((k % 2) == 0) begin
				se_nx[k].ss = sqq_q[k].ss - $signed({3'b000, ns[30:0]});
				se_nx[k].cs = sqq_q[k].cs - $signed({3'b000, nc[30:0]});
			end else begin
				se_nx[k].ss = sqq_q[k].ss + $signed({3'b000, ns[30:0]});
				se_nx[k].cs = sqq_q[k].cs + $signed({3'b000, nc[30:0]});
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [66:0] prs, prc;
		if (ben) begin
			for (int k = 0; k < SERIES_TERMS; k++) begin
				sm_q[k]  <= se_in[k];
				sm_ps[k] <= {32'd0, se_in[k].ts} * {31'd0, se_in[k].x2};
				sm_pc[k] <= {32'd0, se_in[k].tc} * {31'd0, se_in[k].x2};

				prs      = {34'd0, sm_ps[k][62:30]} * {33'd0, sin_rcp(3'(k + 1))};
				prc      = {34'd0, sm_pc[k][62:30]} * {33'd0, cos_rcp(3'(k + 1))};
				sqq_q[k] <= sm_q[k];
				qs_q[k]  <= sm_ps[k][62:30];
				qc_q[k]  <= sm_pc[k][62:30];
				es_q[k]  <= prs[66:34];
				ec_q[k]  <= prc[66:34];

				se_q[k + 1] <= se_nx[k];
			end
		end
	end

	// Clamp sine and cosine to [0, 1], apply the quadrant signs, check the threshold.
	always_comb begin
		if (se_q[SERIES_TERMS].ss[33]) s_cl = '0;
		else if (se_q[SERIES_TERMS].ss > $signed({3'b000, ONE_Q30})) s_cl = ONE_Q30;
		else s_cl = se_q[SERIES_TERMS].ss[30:0];
		if (se_q[SERIES_TERMS].cs[33]) c_cl = '0;
		else if (se_q[SERIES_TERMS].cs > $signed({3'b000, ONE_Q30})) c_cl = ONE_Q30;
		else c_cl = se_q[SERIES_TERMS].cs[30:0];
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			cl_q.smag  <= s_cl;
			cl_q.sgn   <= se_q[SERIES_TERMS].sneg && (s_cl != '0);
			cl_q.above <= se_q[SERIES_TERMS].theta > {1'b0, thr};
			cl_q.theta <= se_q[SERIES_TERMS].theta;
			cl_q.w     <= se_q[SERIES_TERMS].cneg ? 32'(-{1'b0, c_cl}) : {1'b0, c_cl};
			cl_q.v     <= se_q[SERIES_TERMS].v;
		end
	end

	// Scale division sin * 2^28 / theta, one quotient bit per stage after an overflow check.
	always_comb begin
		logic [62:0] trial;
		for (int i = 0; i < 31; i++) begin
			trial    = {31'd0, dv_q[i].theta} << (30 - i);
			dv_nx[i] = dv_q[i];
			if (dv_q[i].rem >= trial) begin
				dv_nx[i].rem          = dv_q[i].rem - trial;
				dv_nx[i].quo[30 - i]  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			dv_q[0].rem   <= {4'd0, cl_q.smag, 28'd0};
			dv_q[0].quo   <= '0;
			dv_q[0].theta <= cl_q.theta;
			dv_q[0].ovf   <= {4'd0, cl_q.smag, 28'd0} >= {cl_q.theta, 31'd0};
			dv_q[0].above <= cl_q.above;
			dv_q[0].sgn   <= cl_q.sgn;
			dv_q[0].w     <= cl_q.w;
			dv_q[0].v     <= cl_q.v;
			for (int i = 0; i < 31; i++) dv_q[i + 1] <= dv_nx[i];
		end
	end

	// Scale selection and the component products.
	always_comb begin
		if (!dv_q[31].above) scl = ONE_Q30;
		else if (dv_q[31].ovf || dv_q[31].quo > ONE_Q30) scl = ONE_Q30;
		else scl = dv_q[31].quo;
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			mu_m_q[0] <= {31'd0, mag32(dv_q[31].v.x)} * {32'd0, scl};
			mu_m_q[1] <= {31'd0, mag32(dv_q[31].v.y)} * {32'd0, scl};
			mu_m_q[2] <= {31'd0, mag32(dv_q[31].v.z)} * {32'd0, scl};
			mu_n_q[0] <= dv_q[31].v.x[31] ^ (dv_q[31].above && dv_q[31].sgn);
			mu_n_q[1] <= dv_q[31].v.y[31] ^ (dv_q[31].above && dv_q[31].sgn);
			mu_n_q[2] <= dv_q[31].v.z[31] ^ (dv_q[31].above && dv_q[31].sgn);
			mu_w_q    <= dv_q[31].w;
		end
	end

	// Saturate to one and apply the sign.
	always_comb begin
		logic [34:0] m;
		logic [31:0] c;
		for (int i = 0; i < 3; i++) begin
			m     = mu_m_q[i][62:28];
			c     = (m > {4'd0, ONE_Q30}) ? {1'b0, ONE_Q30} : m[31:0];
			pk[i] = mu_n_q[i] ? 32'(-c) : c;
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			res_q.x <= $signed(pk[0]);
			res_q.y <= $signed(pk[1]);
			res_q.z <= $signed(pk[2]);
			res_q.w <= $signed(mu_w_q);
		end
	end

endmodule

### src/quaternion_exponential.sv
// Top level of the pure quaternion exponential block.
//
// Takes the vector part (vec_x, vec_y, vec_z, signed Q4.28) and returns
// exp_x, exp_y, exp_z = scale * component and exp_w = cos(theta), all signed
// Q2.30 saturated to [-1.0, +1.0], where theta = |v| and scale is
// sin(theta)/theta when theta is above small_angle_threshold, else 1.0.
// One word is accepted every cycle and one result leaves every cycle when
// the output is not stalled. From acceptance to result a word passes the
// 3 front stages, the 4-entry queue and the 93 back stages, set mostly by
// the 32-stage square root, the 21-stage sine/cosine series and the
// 32-stage scale divider. The threshold register is written through
// cfg_valid/cfg_data, which is always ready, and must only change while
// no word is in flight.
module quaternion_exponential import qexp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] exp_x,
	output logic signed [31:0] exp_y,
	output logic signed [31:0] exp_z,
	output logic signed [31:0] exp_w,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [30:0]        cfg_data
);

	vec_t        vec_in;
	work_t       push_word, head;
	logic        push, full, pop, nonempty;
	logic [30:0] thr_q;
	res_t        res;

	assign vec_in.x = vec_x;
	assign vec_in.y = vec_y;
	assign vec_in.z = vec_z;

	// Threshold register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THRESH_RESET;
		else if (cfg_valid && cfg_ready) thr_q <= cfg_data;
	end

	qexp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.vec_in    (vec_in),
		.q_full    (full),
		.push      (push),
		.push_word (push_word)
	);

	qexp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.nonempty  (nonempty)
	);

	qexp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (nonempty),
		.q_word    (head),
		.pop       (pop),
		.thr       (thr_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign exp_x = res.x;
	assign exp_y = res.y;
	assign exp_z = res.z;
	assign exp_w = res.w;

endmodule

### src/qexp_checker.sv
// Port checker for the quaternion exponential block and its bind statement.
module qexp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] exp_x,
	input logic signed [31:0] exp_y,
	input logic signed [31:0] exp_z,
	input logic signed [31:0] exp_w
);

	// A stalled result word stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(exp_x) && $stable(exp_y)
			&& $stable(exp_z) && $stable(exp_w))
		else $error("result word changed while stalled");

	// The cosine output stays within plus or minus one.
	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (exp_w <= 32'sh4000_0000) && (exp_w >= -32'sh4000_0000))
		else $error("exp_w outside unit range");

	// The scaled components saturate to plus or minus one.
	a_v_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (exp_x <= 32'sh4000_0000) && (exp_x >= -32'sh4000_0000)
			&& (exp_y <= 32'sh4000_0000) && (exp_y >= -32'sh4000_0000)
			&& (exp_z <= 32'sh4000_0000) && (exp_z >= -32'sh4000_0000))
		else $error("vector output outside unit range");

endmodule

bind quaternion_exponential qexp_checker u_chk (.*);
